### rtl/conductor_fresnel_reflectance_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the conductor Fresnel reflectance unit
// Implication and next-cycle checks, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONDUCTOR_FRESNEL_REFLECTANCE_UNIT_MACROS_SVH
`define CONDUCTOR_FRESNEL_REFLECTANCE_UNIT_MACROS_SVH
`ifndef SYNTH
`define CFR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("cfr: implication check failed");
`define CFR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("cfr: next-cycle check failed");
`else
`define CFR_ASSERT_IMP(lbl, ante, cons)
`define CFR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Widths and pipeline depths shared by the reflectance lanes.
// ----------------------------------------------------------------------------
package cfr_pkg;

	localparam int IN_W      = 16;
	localparam int SQ_W      = 24;  // eta^2, k^2 in Q.16
	localparam int C2_W      = 17;  // cos^2, sin^2 in Q.16
	localparam int T0_W      = 26;  // signed e2 - k2 - s2
	localparam int RAD_W     = 52;  // square root radicand
	localparam int ROOT_W    = RAD_W / 2;
	localparam int SQ_STEPS  = RAD_W / 2;
	localparam int ABT_W     = 28;
	localparam int T1_W      = 27;
	localparam int T2P_W     = ROOT_W + IN_W;
	localparam int T2_W      = 24;
	localparam int RS_W      = 28;
	localparam int T3_W      = 44;
	localparam int T4_W      = T2_W + C2_W;
	localparam int DIV_W     = 45;
	localparam int Q_W       = 30;
	localparam int DIV_STEPS = Q_W;
	localparam int PROD_W    = 2 * (Q_W + 1);

	localparam logic [IN_W-1:0] COS_ONE = IN_W'(32768);

	// front 5, root, ab stage, root, 5 stages to the dividers, divide, 2 back
	localparam int LANE_LAT = 5 + SQ_STEPS + 1 + SQ_STEPS + 5 + DIV_STEPS + 2;

endpackage

### rtl/cfr_sqrt.sv
// ----------------------------------------------------------------------------
// cfr_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cfr_sqrt (
	input  logic                         clk,
	input  logic [cfr_pkg::RAD_W-1:0]    radicand,
	output logic [cfr_pkg::ROOT_W-1:0]   root
);
	import cfr_pkg::*;

	logic [RAD_W-1:0] x_s   [SQ_STEPS];
	logic [RAD_W-1:0] res_s [SQ_STEPS];
	logic [RAD_W-1:0] x_in  [SQ_STEPS];
	logic [RAD_W-1:0] res_in[SQ_STEPS];
	logic [RAD_W-1:0] x_nx  [SQ_STEPS];
	logic [RAD_W-1:0] res_nx[SQ_STEPS];

	always_comb begin
		x_in[0]   = radicand;
		res_in[0] = '0;
		for (int i = 1; i < SQ_STEPS; i++) begin
			x_in[i]   = x_s[i-1];
			res_in[i] = res_s[i-1];
		end
	end

	always_comb begin
		logic [RAD_W:0] bitv;
		logic [RAD_W:0] trial;
		for (int i = 0; i < SQ_STEPS; i++) begin
			bitv  = (RAD_W+1)'(1) << (2 * (SQ_STEPS - 1 - i));
			trial = {1'b0, res_in[i]} + bitv;
			if ({1'b0, x_in[i]} >= trial) begin
				x_nx[i]   = x_in[i] - trial[RAD_W-1:0];
				res_nx[i] = (res_in[i] >> 1) + bitv[RAD_W-1:0];
			end else begin
				x_nx[i]   = x_in[i];
				res_nx[i] = res_in[i] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SQ_STEPS; i++) begin
			x_s[i]   <= x_nx[i];
			res_s[i] <= res_nx[i];
		end
	end

	assign root = res_s[SQ_STEPS-1][ROOT_W-1:0];

endmodule

### rtl/cfr_div.sv
// ----------------------------------------------------------------------------
// cfr_div
// Pipelined fraction n/d in Q.30 by restoring division, one bit per stage.
// ----------------------------------------------------------------------------
module cfr_div (
	input  logic                       clk,
	input  logic [cfr_pkg::DIV_W-1:0]  num,
	input  logic [cfr_pkg::DIV_W-1:0]  den,
	output logic [cfr_pkg::Q_W:0]      quo
);
	import cfr_pkg::*;

	logic [DIV_W:0]   rem_s [DIV_STEPS];
	logic [Q_W-1:0]   q_s   [DIV_STEPS];
	logic [DIV_W-1:0] d_s   [DIV_STEPS];
	logic             one_s [DIV_STEPS];

	logic [DIV_W:0]   rem_in[DIV_STEPS];
	logic [Q_W-1:0]   q_in  [DIV_STEPS];
	logic [DIV_W-1:0] d_in  [DIV_STEPS];
	logic             one_in[DIV_STEPS];
	logic [DIV_W:0]   rem_nx[DIV_STEPS];
	logic [Q_W-1:0]   q_nx  [DIV_STEPS];

	always_comb begin
		rem_in[0] = {1'b0, num};
		q_in[0]   = '0;
		d_in[0]   = den;
		// zero denominator or a ratio of one or more reads as full scale
		one_in[0] = (den == '0) || (num >= den);
		for (int i = 1; i < DIV_STEPS; i++) begin
			rem_in[i] = rem_s[i-1];
			q_in[i]   = q_s[i-1];
			d_in[i]   = d_s[i-1];
			one_in[i] = one_s[i-1];
		end
	end

	always_comb begin
		logic [DIV_W:0] r2;
		for (int i = 0; i < DIV_STEPS; i++) begin
			r2 = {rem_in[i][DIV_W-1:0], 1'b0};
			if (r2 >= {1'b0, d_in[i]}) begin
				rem_nx[i] = r2 - {1'b0, d_in[i]};
				q_nx[i]   = {q_in[i][Q_W-2:0], 1'b1};
			end else begin
				rem_nx[i] = r2;
				q_nx[i]   = {q_in[i][Q_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DIV_STEPS; i++) begin
			rem_s[i] <= rem_nx[i];
			q_s[i]   <= q_nx[i];
			d_s[i]   <= d_in[i];
			one_s[i] <= one_in[i];
		end
	end

	assign quo = one_s[DIV_STEPS-1] ? ((Q_W+1)'(1) << Q_W) : {1'b0, q_s[DIV_STEPS-1]};

endmodule

### rtl/cfr_lane.sv
// ----------------------------------------------------------------------------
// cfr_lane
// One colour channel: conductor Fresnel reflectance, fully pipelined.
// ----------------------------------------------------------------------------
module cfr_lane (
	input  logic                      clk,
	input  logic [cfr_pkg::IN_W-1:0]  eta,
	input  logic [cfr_pkg::IN_W-1:0]  absorb,
	input  logic [cfr_pkg::IN_W-1:0]  cosv,
	output logic [cfr_pkg::IN_W-1:0]  refl
);
	import cfr_pkg::*;

	typedef struct packed {
		logic signed [T0_W-1:0] t0;
		logic [C2_W-1:0]        c2;
		logic [C2_W-1:0]        s2;
		logic [IN_W-1:0]        c;
	} side1_t;

	typedef struct packed {
		logic [T1_W-1:0]   t1;
		logic [ROOT_W-1:0] ab;
		logic [C2_W-1:0]   c2;
		logic [C2_W-1:0]   s2;
		logic [IN_W-1:0]   c;
	} side2_t;

	// front end: squares and a^2+b^2 radicand
	logic [2*IN_W-1:0] ee_s1, kk_s1, cc_s1;
	logic [IN_W-1:0]   c_s1, c_s2, c_s3, c_s4;
	logic [SQ_W-1:0]   e2_s2, k2_s2, e2_s3, k2_s3;
	logic [C2_W-1:0]   c2_s2, c2_s3, s2_s3, c2_s4, s2_s4;
	logic signed [T0_W-1:0] t0_s3, t0_s4;
	logic [C2_W-1:0]   s2_w;
	logic signed [T0_W-1:0] t0_w;
	logic signed [RAD_W-1:0] tsq_w;
	logic [RAD_W-1:0]  tsq_s4, rad_s5;
	logic [2*SQ_W-1:0] ek_s4;
	side1_t            side1_s5;
	side1_t            side1_q [SQ_STEPS];

	always_ff @(posedge clk) begin
		ee_s1 <= eta * eta;
		kk_s1 <= absorb * absorb;
		cc_s1 <= cosv * cosv;
		c_s1  <= cosv;
	end

	always_ff @(posedge clk) begin
		e2_s2 <= SQ_W'((33'(ee_s1) + 33'd128) >> 8);
		k2_s2 <= SQ_W'((33'(kk_s1) + 33'd128) >> 8);
		c2_s2 <= C2_W'((33'(cc_s1) + 33'd8192) >> 14);
		c_s2  <= c_s1;
	end

	assign s2_w = C2_W'(65536) - c2_s2;
	assign t0_w = $signed(T0_W'(e2_s2)) - $signed(T0_W'(k2_s2)) - $signed(T0_W'(s2_w));

	always_ff @(posedge clk) begin
		t0_s3 <= t0_w;
		e2_s3 <= e2_s2;
		k2_s3 <= k2_s2;
		c2_s3 <= c2_s2;
		s2_s3 <= s2_w;
		c_s3  <= c_s2;
	end

	assign tsq_w = t0_s3 * t0_s3;

	always_ff @(posedge clk) begin
		tsq_s4 <= $unsigned(tsq_w);
		ek_s4  <= e2_s3 * k2_s3;
		t0_s4  <= t0_s3;
		c2_s4  <= c2_s3;
		s2_s4  <= s2_s3;
		c_s4   <= c_s3;
	end

	always_ff @(posedge clk) begin
		rad_s5      <= tsq_s4 + RAD_W'({ek_s4, 2'b00});
		side1_s5.t0 <= t0_s4;
		side1_s5.c2 <= c2_s4;
		side1_s5.s2 <= s2_s4;
		side1_s5.c  <= c_s4;
	end

	// first root: |eta^2 - k^2 - sin^2 + 2i eta k|
	logic [ROOT_W-1:0] ab_w;

	cfr_sqrt u_sqrt_ab (
		.clk      (clk),
		.radicand (rad_s5),
		.root     (ab_w)
	);

	always_ff @(posedge clk) begin
		side1_q[0] <= side1_s5;
		for (int i = 1; i < SQ_STEPS; i++) begin
			side1_q[i] <= side1_q[i-1];
		end
	end

	side1_t                  sd1;
	logic signed [ABT_W-1:0] abt_w;
	logic [RAD_W-1:0]        rad2_s6;
	side2_t                  side2_s6;
	side2_t                  side2_q [SQ_STEPS];

	assign sd1   = side1_q[SQ_STEPS-1];
	assign abt_w = $signed(ABT_W'(ab_w)) + ABT_W'(sd1.t0);

	always_ff @(posedge clk) begin
		rad2_s6     <= abt_w[ABT_W-1] ? '0 : RAD_W'({abt_w[ABT_W-2:0], 15'd0});
		side2_s6.t1 <= T1_W'(ab_w) + T1_W'(sd1.c2);
		side2_s6.ab <= ab_w;
		side2_s6.c2 <= sd1.c2;
		side2_s6.s2 <= sd1.s2;
		side2_s6.c  <= sd1.c;
	end

	// second root: 2a^2 scaled
	logic [ROOT_W-1:0] a_w;

	cfr_sqrt u_sqrt_a (
		.clk      (clk),
		.radicand (rad2_s6),
		.root     (a_w)
	);

	always_ff @(posedge clk) begin
		side2_q[0] <= side2_s6;
		for (int i = 1; i < SQ_STEPS; i++) begin
			side2_q[i] <= side2_q[i-1];
		end
	end

	side2_t           side2_s7, side2_s8;
	logic [T2P_W-1:0] t2p_s7;
	logic [T2P_W:0]   t2r_w;
	logic [T2_W-1:0]  t2_s8;

	always_ff @(posedge clk) begin
		t2p_s7   <= T2P_W'(a_w) * T2P_W'(side2_q[SQ_STEPS-1].c);
		side2_s7 <= side2_q[SQ_STEPS-1];
	end

	assign t2r_w = {1'b0, t2p_s7} + (T2P_W+1)'(16384);

	always_ff @(posedge clk) begin
		t2_s8    <= t2r_w[T2_W+13:14];
		side2_s8 <= side2_s7;
	end

	// numerators and denominators of the two ratios
	logic [RS_W-1:0]        rsn_s9, rsd_s9, rsn_s10, rsd_s10, rsn_s11, rsd_s11;
	logic [T4_W-1:0]        t4_s9, t4_s10;
	logic [C2_W+ROOT_W-1:0] t3a_s9;
	logic [2*C2_W-1:0]      t3b_s9;
	logic [T3_W-1:0]        t3_s10;
	logic [DIV_W-1:0]       rpn_s11, rpd_s11;

	always_ff @(posedge clk) begin
		rsn_s9 <= (RS_W'(side2_s8.t1) > RS_W'(t2_s8)) ?
			RS_W'(side2_s8.t1) - RS_W'(t2_s8) : '0;
		rsd_s9 <= RS_W'(side2_s8.t1) + RS_W'(t2_s8);
		t4_s9  <= T4_W'(t2_s8) * T4_W'(side2_s8.s2);
		t3a_s9 <= (C2_W+ROOT_W)'(side2_s8.c2) * (C2_W+ROOT_W)'(side2_s8.ab);
		t3b_s9 <= (2*C2_W)'(side2_s8.s2) * (2*C2_W)'(side2_s8.s2);
	end

	always_ff @(posedge clk) begin
		t3_s10  <= T3_W'(t3a_s9) + T3_W'(t3b_s9);
		t4_s10  <= t4_s9;
		rsn_s10 <= rsn_s9;
		rsd_s10 <= rsd_s9;
	end

	always_ff @(posedge clk) begin
		rpn_s11 <= (T3_W'(t4_s10) < t3_s10) ? DIV_W'(t3_s10 - T3_W'(t4_s10)) : '0;
		rpd_s11 <= DIV_W'(t3_s10) + DIV_W'(t4_s10);
		rsn_s11 <= rsn_s10;
		rsd_s11 <= rsd_s10;
	end

	logic [Q_W:0] rs_w, ratio_w;

	cfr_div u_div_rs (
		.clk (clk),
		.num (DIV_W'(rsn_s11)),
		.den (DIV_W'(rsd_s11)),
		.quo (rs_w)
	);

	cfr_div u_div_rp (
		.clk (clk),
		.num (rpn_s11),
		.den (rpd_s11),
		.quo (ratio_w)
	);

	logic [Q_W:0]    rs_s12;
	logic [PROD_W-1:0] prod_s12;
	logic [PROD_W:0] rpr_w;
	logic [Q_W:0]    rp_w;
	logic [Q_W+2:0]  sum_w;
	logic [Q_W-14:0] r_w;

	always_ff @(posedge clk) begin
		rs_s12   <= rs_w;
		prod_s12 <= PROD_W'(rs_w) * PROD_W'(ratio_w);
	end

	assign rpr_w = {1'b0, prod_s12} + (PROD_W+1)'(1 << (Q_W - 1));
	assign rp_w  = rpr_w[2*Q_W:Q_W];
	assign sum_w = (Q_W+3)'(rs_s12) + (Q_W+3)'(rp_w) + (Q_W+3)'(32768);
	assign r_w   = sum_w[Q_W+2:16];

	always_ff @(posedge clk) begin
		refl <= (r_w > (Q_W-13)'(COS_ONE)) ? COS_ONE : IN_W'(r_w);
	end

endmodule

### rtl/conductor_fresnel_reflectance_unit.sv
// A word accepted by start is on the result ports, with done high, for a single cycle once it
// has passed the valid pipeline vld_q and done_q. Throughput: one word every cycle; busy stays low.
// Depth is set by the two 26-stage square root pipes and the 30-stage dividers in each lane.
// Reset clears the valid pipeline and done; datapath registers are not reset.
// ----------------------------------------------------------------------------
// conductor_fresnel_reflectance_unit
// Three colour lanes side by side; results captured together into the output registers.
// ----------------------------------------------------------------------------
`include "conductor_fresnel_reflectance_unit_macros.svh"

module conductor_fresnel_reflectance_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [cfr_pkg::IN_W-1:0]  eta_red,
	input  logic [cfr_pkg::IN_W-1:0]  eta_green,
	input  logic [cfr_pkg::IN_W-1:0]  eta_blue,
	input  logic [cfr_pkg::IN_W-1:0]  absorb_red,
	input  logic [cfr_pkg::IN_W-1:0]  absorb_green,
	input  logic [cfr_pkg::IN_W-1:0]  absorb_blue,
	input  logic [cfr_pkg::IN_W-1:0]  cos_incidence,
	output logic                      done,
	output logic [cfr_pkg::IN_W-1:0]  refl_red,
	output logic [cfr_pkg::IN_W-1:0]  refl_green,
	output logic [cfr_pkg::IN_W-1:0]  refl_blue
);
	import cfr_pkg::*;

	logic                accept;
	logic [IN_W-1:0]     cos_sat;
	logic [LANE_LAT-1:0] vld_q;
	logic                done_q;
	logic [IN_W-1:0]     lane_r, lane_g, lane_b;
	logic [IN_W-1:0]     red_q, green_q, blue_q;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign cos_sat = (cos_incidence > COS_ONE) ? COS_ONE : cos_incidence;

	cfr_lane u_lane_red (
		.clk    (clk),
		.eta    (eta_red),
		.absorb (absorb_red),
		.cosv   (cos_sat),
		.refl   (lane_r)
	);

	cfr_lane u_lane_green (
		.clk    (clk),
		.eta    (eta_green),
		.absorb (absorb_green),
		.cosv   (cos_sat),
		.refl   (lane_g)
	);

	cfr_lane u_lane_blue (
		.clk    (clk),
		.eta    (eta_blue),
		.absorb (absorb_blue),
		.cosv   (cos_sat),
		.refl   (lane_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[LANE_LAT-2:0], accept};
			done_q <= vld_q[LANE_LAT-1];
		end
	end

	// merge: capture the three lanes together when the word reaches the end
	always_ff @(posedge clk) begin
		if (vld_q[LANE_LAT-1]) begin
			red_q   <= lane_r;
			green_q <= lane_g;
			blue_q  <= lane_b;
		end
	end

	assign done       = done_q;
	assign refl_red   = red_q;
	assign refl_green = green_q;
	assign refl_blue  = blue_q;

	`CFR_ASSERT_IMP(a_refl_range, done, (refl_red <= COS_ONE) && (refl_green <= COS_ONE) && (refl_blue <= COS_ONE))
	`CFR_ASSERT_IMP(a_done_origin, done, $past(accept, LANE_LAT + 1))
	`CFR_ASSERT_NXT(a_no_phantom, !accept, !vld_q[0])

endmodule

### tb/sv/conductor_fresnel_reflectance_unit_tb.sv
// ----------------------------------------------------------------------------
// conductor_fresnel_reflectance_unit_tb
// Drives complex indices and incidence cosines into the three-lane unit and
// checks every reflectance word against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module conductor_fresnel_reflectance_unit_tb;

	import cfr_pkg::*;

	typedef struct packed {
		logic [IN_W-1:0] eta_r, eta_g, eta_b;
		logic [IN_W-1:0] k_r, k_g, k_b;
		logic [IN_W-1:0] cosi;
	} surface_t;

	typedef struct packed {
		logic [IN_W-1:0] r, g, b;
	} refl_t;

	localparam int NUM_RANDOM  = 1130;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN       = 120;

	logic clk, arst_n, start, busy, done;
	logic [IN_W-1:0] eta_red, eta_green, eta_blue;
	logic [IN_W-1:0] absorb_red, absorb_green, absorb_blue, cos_incidence;
	logic [IN_W-1:0] refl_red, refl_green, refl_blue;

	surface_t pending_words[$];
	refl_t    expected_refl[$];
	int       err_count, words_sent, words_checked, cycle_count;
	bit       stimulus_loaded;

	conductor_fresnel_reflectance_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.eta_red(eta_red), .eta_green(eta_green), .eta_blue(eta_blue),
		.absorb_red(absorb_red), .absorb_green(absorb_green),
		.absorb_blue(absorb_blue), .cos_incidence(cos_incidence),
		.done(done), .refl_red(refl_red), .refl_green(refl_green),
		.refl_blue(refl_blue)
	);

	always #2 clk = ~clk;

	function automatic bit [63:0] int_sqrt(bit [63:0] x);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// floor(n * 2^30 / d); a zero or non-larger denominator gives one
	function automatic bit [63:0] ratio_q30(bit [63:0] n, bit [63:0] d);
		bit [63:0] q, rem;
		if (d == 0 || n >= d)
			return 64'd1 << 30;
		q = 0;
		rem = n;
		for (int i = 0; i < 30; i++) begin
			rem <<= 1;
			q <<= 1;
			if (rem >= d) begin
				rem -= d;
				q |= 1;
			end
		end
		return q;
	endfunction

	function automatic logic [IN_W-1:0] lane_reflectance(bit [63:0] eta, bit [63:0] kap,
			bit [63:0] c);
		bit [63:0] c2, s2, e2, k2, mag, ab, a, t1, t2, rs, t3, t4, rat, rp, r;
		longint t0, abt;
		c2 = (c * c + 64'd8192) >> 14;
		s2 = 64'd65536 - c2;
		e2 = (eta * eta + 64'd128) >> 8;
		k2 = (kap * kap + 64'd128) >> 8;
		t0 = longint'(e2) - longint'(k2) - longint'(s2);
		mag = (t0 < 0) ? 64'(-t0) : 64'(t0);
		ab = int_sqrt(mag * mag + 64'd4 * e2 * k2);
		abt = longint'(ab) + t0;
		a = int_sqrt((abt > 0 ? 64'(abt) : 64'd0) << 15);
		t1 = ab + c2;
		t2 = (a * c + 64'd16384) >> 14;
		rs = ratio_q30(t1 > t2 ? t1 - t2 : 64'd0, t1 + t2);
		t3 = c2 * ab + s2 * s2;
		t4 = t2 * s2;
		rat = ratio_q30(t3 > t4 ? t3 - t4 : 64'd0, t3 + t4);
		rp = (rs * rat + (64'd1 << 29)) >> 30;
		r = (rs + rp + 64'd32768) >> 16;
		if (r > 64'd32768)
			r = 64'd32768;
		return r[IN_W-1:0];
	endfunction

	function automatic refl_t predict_reflectance(surface_t s);
		refl_t o;
		bit [63:0] c;
		c = (s.cosi > COS_ONE) ? 64'(COS_ONE) : 64'(s.cosi);
		o.r = lane_reflectance(64'(s.eta_r), 64'(s.k_r), c);
		o.g = lane_reflectance(64'(s.eta_g), 64'(s.k_g), c);
		o.b = lane_reflectance(64'(s.eta_b), 64'(s.k_b), c);
		return o;
	endfunction

	function automatic surface_t make_word(int er, int eg, int eb, int kr, int kg, int kb,
			int c);
		surface_t s;
		s = {IN_W'(er), IN_W'(eg), IN_W'(eb), IN_W'(kr), IN_W'(kg), IN_W'(kb), IN_W'(c)};
		return s;
	endfunction

	function automatic logic [IN_W-1:0] rand_index();
		case ($urandom_range(0, 9))
			0:       return IN_W'($urandom);
			1:       return IN_W'($urandom_range(0, 64));
			default: return IN_W'($urandom_range(0, 24000));
		endcase
	endfunction

	// driver: next word chosen at the falling edge once the last one was taken
	bit accepted_last;
	always @(negedge clk) begin
		surface_t w;
		bit no_idle;
		if (arst_n && (accepted_last || !start)) begin
			no_idle = (words_sent >= 300 && words_sent < 500);
			if (pending_words.size() != 0 && (no_idle || $urandom_range(0, 99) >= 29)) begin
				w = pending_words.pop_front();
				{eta_red, eta_green, eta_blue, absorb_red, absorb_green, absorb_blue,
					cos_incidence} <= w;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check the result word, then record any accepted input word
	always @(posedge clk) begin
		refl_t exp_w;
		surface_t in_w;
		bit took;
		took = 1'b0;
		if (arst_n) begin
			if (done) begin
				if (expected_refl.size() == 0) begin
					$display("%0t: unexpected word r=%0d g=%0d b=%0d", $time,
						refl_red, refl_green, refl_blue);
					err_count++;
				end else begin
					exp_w = expected_refl.pop_front();
					words_checked++;
					if (refl_red !== exp_w.r) begin
						$display("%0t: refl_red exp %0d got %0d", $time, exp_w.r, refl_red);
						err_count++;
					end
					if (refl_green !== exp_w.g) begin
						$display("%0t: refl_green exp %0d got %0d", $time, exp_w.g,
							refl_green);
						err_count++;
					end
					if (refl_blue !== exp_w.b) begin
						$display("%0t: refl_blue exp %0d got %0d", $time, exp_w.b, refl_blue);
						err_count++;
					end
				end
			end
			if (start && !busy) begin
				in_w = {eta_red, eta_green, eta_blue, absorb_red, absorb_green, absorb_blue,
					cos_incidence};
				expected_refl.push_back(predict_reflectance(in_w));
				words_sent++;
				took = 1'b1;
			end
		end
		accepted_last <= took;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		clk = 0; arst_n = 0; start = 0;
		{eta_red, eta_green, eta_blue, absorb_red, absorb_green, absorb_blue,
			cos_incidence} = '0;
		// directed: extremes, zero denominators, cosine saturation, typical metals
		pending_words.push_back(make_word(0, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(0, 0, 0, 0, 0, 0, 32768));
		pending_words.push_back(make_word(65535, 65535, 65535, 65535, 65535, 65535, 65535));
		pending_words.push_back(make_word(65535, 0, 4096, 0, 65535, 0, 32768));
		pending_words.push_back(make_word(4096, 4096, 4096, 0, 0, 0, 32768));
		pending_words.push_back(make_word(4096, 4096, 4096, 0, 0, 0, 0));
		pending_words.push_back(make_word(0, 1, 2, 65535, 1, 2, 1));
		pending_words.push_back(make_word(6144, 6144, 6144, 0, 4096, 16384, 32769));
		pending_words.push_back(make_word(800, 1200, 1900, 15000, 11000, 8000, 23170));
		pending_words.push_back(make_word(760, 3800, 6000, 14000, 10000, 9000, 16384));
		pending_words.push_back(make_word(12000, 3000, 200, 12000, 3000, 200, 100));
		pending_words.push_back(make_word(65535, 65535, 65535, 0, 0, 0, 0));
		pending_words.push_back(make_word(0, 0, 0, 65535, 65535, 65535, 32768));
		pending_words.push_back(make_word(4096, 8192, 2048, 1, 1, 1, 49152));
		pending_words.push_back(make_word(43690, 21845, 32768, 21845, 43690, 32767,
			32767));
		for (int i = 0; i < NUM_RANDOM; i++)
			pending_words.push_back(make_word(rand_index(), rand_index(), rand_index(),
				rand_index(), rand_index(), rand_index(),
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 32768)));
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1;
		wait (pending_words.size() == 0 && !start);
		wait (expected_refl.size() == 0);
		repeat (DRAIN) @(posedge clk);
		$display("%0d words accepted, %0d results checked", words_sent, words_checked);
		$display("covered index extremes, zero denominators and cosine saturation");
		if (err_count == 0 && expected_refl.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
